// ===== design/software_timer_pool_defines.svh =====
// ----------------------------------------------------------------------------
// Timer pool assertion macros
// Assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_POOL_DEFINES_SVH
`define SOFTWARE_TIMER_POOL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define STP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define STP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define STP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer pool package
// Shared constants, codes and types of the timer pool.
// ----------------------------------------------------------------------------
package stp_pkg;
  localparam int TimerSlots = 16;
  localparam int GenBits = 8;
  localparam int IdW = 12;
  localparam int PendW = 5;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;
  localparam logic [2:0] OP_DONE   = 3'd6;
  localparam logic [2:0] OP_BAD    = 3'd7;

  localparam logic [2:0] S_OK          = 3'd0;
  localparam logic [2:0] S_BAD_INTERVAL= 3'd1;
  localparam logic [2:0] S_BAD_MODE    = 3'd2;
  localparam logic [2:0] S_FULL        = 3'd3;
  localparam logic [2:0] S_ID_INVALID  = 3'd4;
  localparam logic [2:0] S_NOT_CREATED = 3'd5;
  localparam logic [2:0] S_NOT_STARTED = 3'd6;

  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_CREATED  = 2'd1;
  localparam logic [1:0] ST_TICKING  = 2'd2;
  localparam logic [1:0] ST_DELETING = 2'd3;

  localparam logic [1:0] M_ONCE     = 2'd0;
  localparam logic [1:0] M_PERIODIC = 2'd1;
  localparam logic [1:0] M_NODEL    = 2'd2;
  localparam logic [1:0] M_INVALID  = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] timer_id;
    logic [31:0] interval;
    logic [1:0]  mode;
    logic [31:0] user_tag;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] result_id;
    logic [31:0] remaining_ticks;
    logic        expired;
    logic [31:0] expired_tag;
    logic [15:0] overrun_count;
    logic        any_expired;
    logic        last;
  } rsp_t;
endpackage

// ===== design/stp_if.sv =====
// ----------------------------------------------------------------------------
// Timer pool channel
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface stp_if #(parameter type T = stp_pkg::cmd_t) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/software_timer_pool.sv =====
// ----------------------------------------------------------------------------
// Software timer pool
// Pool of timer slots driven by create/start/stop/delete/query/tick/done words.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  cmd     | in  | operation, timer_id, interval, mode, user_tag
//  rsp     | out | status, result_id, remaining_ticks, expired, expired_tag,
//          |     | overrun_count, any_expired, last
// A command runs through four steps: accept, read the slot memory, modify/write, respond.
// A tick reads and updates every slot in turn, sends an expiry word for each reported expiry
// and then a summary word; every word stalls while the sink holds ready low.
// After reset a clearing pass over all TIMER_SLOTS slots runs before cmd is ready.
`include "software_timer_pool_defines.svh"
module software_timer_pool #(
  parameter int TIMER_SLOTS = stp_pkg::TimerSlots,
  parameter int GEN_BITS = stp_pkg::GenBits
) (
  input logic clk,
  input logic rst,
  stp_if.sink   cmd,
  stp_if.source rsp
);
  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int EW = $clog2(TIMER_SLOTS + 1) + 1;
  // slot word: state, mode, interval, remaining, overrun, pending, gen, tag
  localparam int RW = 2 + 2 + 32 + 32 + 16 + EW + GEN_BITS + 32;

  typedef struct packed {
    logic [1:0]          state;
    logic [1:0]          mode;
    logic [31:0]         interval;
    logic [31:0]         remaining;
    logic [15:0]         overrun;
    logic [EW-1:0]       pending;
    logic [GEN_BITS-1:0] gen;
    logic [31:0]         tag;
  } slot_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_TREAD = 7'b0010000,
    S_TEXEC = 7'b0100000,
    S_OUT   = 7'b1000000
  } fsm_t;

  fsm_t state, state_next;
  stp_pkg::cmd_t req;
  stp_pkg::rsp_t out_word;
  logic out_valid;
  logic tick_done;     // summary word pending after tick walk
  logic any_exp;
  logic [SW-1:0] scan;
  logic [SW-1:0] slot;
  logic [CW-1:0] free_count;
  logic [SW-1:0] free_head;
  logic [EW-1:0] events;
  logic [SW-1:0] fq [TIMER_SLOTS];  // free queue, read at head only
  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  slot_t         ram_wdata, rd;
  logic [RW-1:0] rd_raw;

  stp_slot_ram #(.Depth(TIMER_SLOTS), .Width(RW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rd_raw)
  );
  assign rd = slot_t'(rd_raw);

  // id decode
  logic [11:0] id_gen_full;
  logic [SW-1:0] id_slot;
  assign id_gen_full = 12'(req.timer_id / 12'(TIMER_SLOTS));
  assign id_slot = SW'(req.timer_id % 12'(TIMER_SLOTS));
  logic gen_bad;
  assign gen_bad = id_gen_full > 12'((1 << GEN_BITS) - 1);

  function automatic logic [11:0] mk_id(input logic [GEN_BITS-1:0] g,
                                        input logic [SW-1:0] s);
    logic [31:0] v;
    v = 32'(g) * 32'(TIMER_SLOTS) + 32'(s);
    return v[11:0];
  endfunction

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  // sequencer and slot update
  always_ff @(posedge clk) begin
    logic [SW-1:0] tail;
    logic [31:0] tsum;
    slot_t w;
    logic emit, rel;
    stp_pkg::rsp_t o;
    if (rst) begin
      state <= S_CLEAR;
      scan <= '0;
      free_head <= '0;
      free_count <= CW'(TIMER_SLOTS);
      events <= '0;
      out_valid <= 1'b0;
      ram_we <= 1'b0;
      tick_done <= 1'b0;
      any_exp <= 1'b0;
    end else begin
      ram_we <= 1'b0;
      case (state)
        S_CLEAR: begin
          ram_we <= 1'b1;
          ram_waddr <= scan;
          ram_wdata <= '0;
          fq[scan] <= scan;
          scan <= SW'(scan + 1'b1);
          if (32'(scan) == TIMER_SLOTS - 1) begin
            scan <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            req <= cmd.data;
            if (cmd.data.operation == stp_pkg::OP_TICK) begin
              scan <= '0;
              any_exp <= 1'b0;
              state <= S_TREAD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // memory address settles this cycle
          state <= S_EXEC;
        end
        S_EXEC: begin
          w = rd;
          rel = 1'b0;
          o = '0;
          o.last = 1'b1;
          o.status = stp_pkg::S_OK;
          if (req.operation == stp_pkg::OP_CREATE) begin
            if (req.interval == '0) o.status = stp_pkg::S_BAD_INTERVAL;
            else if (req.mode == stp_pkg::M_INVALID) o.status = stp_pkg::S_BAD_MODE;
            else if (free_count == '0) o.status = stp_pkg::S_FULL;
            else begin
              free_head <= (32'(free_head) == TIMER_SLOTS - 1) ? '0
                                                               : SW'(free_head + 1'b1);
              free_count <= CW'(free_count - 1'b1);
              w.mode = req.mode;
              w.overrun = '0;
              w.interval = req.interval;
              w.tag = req.user_tag;
              w.state = stp_pkg::ST_CREATED;
              o.result_id = mk_id(rd.gen, slot);
              ram_we <= 1'b1;
            end
          end else if (req.operation == stp_pkg::OP_BAD || gen_bad) begin
            o.status = stp_pkg::S_ID_INVALID;
          end else if (rd.gen != GEN_BITS'(id_gen_full)) begin
            o.status = stp_pkg::S_NOT_CREATED;
          end else if (req.operation == stp_pkg::OP_DONE) begin
            if (rd.pending == '0) o.status = stp_pkg::S_NOT_STARTED;
            else begin
              w.pending = EW'(rd.pending - 1'b1);
              if (events != '0) events <= EW'(events - 1'b1);
              rel = (rd.state == stp_pkg::ST_DELETING) && (w.pending == '0);
              ram_we <= 1'b1;
            end
          end else if (rd.state == stp_pkg::ST_UNUSED ||
                       rd.state == stp_pkg::ST_DELETING) begin
            o.status = stp_pkg::S_NOT_CREATED;
          end else if (req.operation == stp_pkg::OP_START) begin
            w.overrun = '0;
            w.state = stp_pkg::ST_TICKING;
            w.remaining = rd.interval;
            ram_we <= 1'b1;
          end else if (req.operation == stp_pkg::OP_STOP) begin
            if (rd.state == stp_pkg::ST_CREATED) o.status = stp_pkg::S_NOT_STARTED;
            else begin
              w.state = stp_pkg::ST_CREATED;
              w.overrun = '0;
              ram_we <= 1'b1;
            end
          end else if (req.operation == stp_pkg::OP_DELETE) begin
            w.overrun = '0;
            w.state = stp_pkg::ST_DELETING;
            rel = (rd.pending == '0);
            ram_we <= 1'b1;
          end else begin
            if (rd.state == stp_pkg::ST_CREATED) o.status = stp_pkg::S_NOT_STARTED;
            else o.remaining_ticks = rd.remaining;
          end
          if (rel) begin
            tsum = 32'(free_head) + 32'(free_count);
            if (tsum >= 32'(TIMER_SLOTS)) tsum = tsum - 32'(TIMER_SLOTS);
            tail = SW'(tsum);
            fq[tail] <= slot;
            if (32'(free_count) < TIMER_SLOTS) free_count <= CW'(free_count + 1'b1);
            w.gen = GEN_BITS'(rd.gen + 1'b1);
            w.state = stp_pkg::ST_UNUSED;
          end
          ram_waddr <= slot;
          ram_wdata <= w;
          out_word <= o;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_TREAD: begin
          state <= S_TEXEC;
        end
        S_TEXEC: begin
          w = rd;
          rel = 1'b0;
          emit = 1'b0;
          o = '0;
          if (rd.state == stp_pkg::ST_TICKING) begin
            w.remaining = rd.remaining - 32'd1;
            if (w.remaining == '0) begin
              any_exp <= 1'b1;
              emit = 32'(events) < TIMER_SLOTS;
              if (emit) begin
                w.pending = EW'(rd.pending + 1'b1);
                events <= EW'(events + 1'b1);
              end
              if (rd.mode == stp_pkg::M_ONCE) w.state = stp_pkg::ST_DELETING;
              else if (rd.mode == stp_pkg::M_NODEL) w.state = stp_pkg::ST_CREATED;
              else begin
                if (rd.overrun != 16'hFFFF) w.overrun = rd.overrun + 16'd1;
                w.remaining = rd.interval;
              end
              o.expired = 1'b1;
              o.result_id = mk_id(rd.gen, scan);
              o.expired_tag = rd.tag;
              o.overrun_count = w.overrun;
              rel = (w.state == stp_pkg::ST_DELETING) && (w.pending == '0);
            end
            ram_we <= 1'b1;
          end
          if (rel) begin
            tsum = 32'(free_head) + 32'(free_count);
            if (tsum >= 32'(TIMER_SLOTS)) tsum = tsum - 32'(TIMER_SLOTS);
            tail = SW'(tsum);
            fq[tail] <= scan;
            if (32'(free_count) < TIMER_SLOTS) free_count <= CW'(free_count + 1'b1);
            w.gen = GEN_BITS'(rd.gen + 1'b1);
            w.state = stp_pkg::ST_UNUSED;
          end
          ram_waddr <= scan;
          ram_wdata <= w;
          tick_done <= (32'(scan) == TIMER_SLOTS - 1);
          if (emit) begin
            out_word <= o;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (32'(scan) == TIMER_SLOTS - 1) begin
            state <= S_OUT;
          end else begin
            scan <= SW'(scan + 1'b1);
            state <= S_TREAD;
          end
        end
        S_OUT: begin
          // hold the word until taken, then resume the walk or finish
          if (!out_valid) begin
            // tick summary
            o = '0;
            o.any_expired = any_exp;
            o.last = 1'b1;
            out_word <= o;
            out_valid <= 1'b1;
            tick_done <= 1'b0;
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
            if (out_word.last) state <= S_IDLE;
            else if (!tick_done) begin
              scan <= SW'(scan + 1'b1);
              state <= S_TREAD;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // read address: the selected slot for commands, the walk index for ticks
  always_comb begin
    if (req.operation == stp_pkg::OP_CREATE) slot = fq[free_head];
    else slot = id_slot;
    ram_raddr = (state == S_TREAD || state == S_TEXEC) ? scan : slot;
  end

  `STP_ASSERT_IMPL(a_ready_idle, clk, rst, cmd.ready, !out_valid)
  `STP_ASSERT_IMPL(a_events_cap, clk, rst, 1'b1, 32'(events) <= TIMER_SLOTS)
  `STP_ASSERT_NEXT(a_last_idle, clk, rst,
                   rsp.valid && rsp.ready && rsp.data.last, state == S_IDLE)
endmodule

// ===== design/stp_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Timer pool slot memory
// One synchronous memory holding every field of a slot; one read, one write.
// ----------------------------------------------------------------------------
module stp_slot_ram #(
  parameter int Depth = stp_pkg::TimerSlots,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/sv/software_timer_pool_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer pool testbench
// Drives create/start/stop/delete/query/tick/done words into the pool with
// random gaps and stalls. Every accepted word is run through a cycle-free
// model of the pool, and the response words that come back are checked
// field by field, in order, against the words that model produces.
// ----------------------------------------------------------------------------
module software_timer_pool_tb;
  localparam int CycleLimit = 600000;
  localparam int Slots = stp_pkg::TimerSlots;

  typedef struct {
    stp_pkg::cmd_t word;
    bit   drain;  // hold this word until every response has come back
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stp_if #(.T(stp_pkg::cmd_t)) cmd (.clk(clk));
  stp_if #(.T(stp_pkg::rsp_t)) rsp (.clk(clk));

  software_timer_pool dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Model state of the pool
  logic [1:0]  pool_state [Slots];
  logic [1:0]  pool_mode [Slots];
  logic [31:0] pool_interval [Slots];
  logic [31:0] pool_left [Slots];
  logic [15:0] pool_overrun [Slots];
  logic [4:0]  pool_pending [Slots];
  logic [7:0]  pool_gen [Slots];
  logic [31:0] pool_tag [Slots];
  logic [3:0]  free_slots [Slots];
  logic [3:0]  free_head;
  logic [4:0]  free_count;
  logic [4:0]  events_open;

  pending_t      word_queue[$];
  stp_pkg::rsp_t expected_rsp[$];

  int errors = 0;
  int cycles = 0;
  int words_in = 0;
  int rsps_seen = 0;
  int expiries_seen = 0;
  bit took = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  bit long_hold_done = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic stp_pkg::rsp_t blank_rsp();
    stp_pkg::rsp_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [11:0] id_of(int s);
    return {pool_gen[s], 4'(s)};
  endfunction

  task automatic free_slot(int s);
    logic [3:0] tail;
    tail = free_head + free_count[3:0];
    free_slots[tail] = 4'(s);
    if (free_count < Slots) free_count++;
    pool_gen[s] = pool_gen[s] + 8'd1;
    pool_state[s] = stp_pkg::ST_UNUSED;
  endtask

  task automatic pool_clear();
    for (int i = 0; i < Slots; i++) begin
      pool_state[i] = stp_pkg::ST_UNUSED;
      pool_mode[i] = '0;
      pool_interval[i] = '0;
      pool_left[i] = '0;
      pool_overrun[i] = '0;
      pool_pending[i] = '0;
      pool_gen[i] = '0;
      pool_tag[i] = '0;
      free_slots[i] = 4'(i);
    end
    free_head = '0;
    free_count = 5'(Slots);
    events_open = '0;
  endtask

  // Apply one word to the model and queue the responses it causes
  task automatic pool_apply(stp_pkg::cmd_t c);
    stp_pkg::rsp_t r;
    int s;
    bit any;
    bit emit;
    logic [1:0] cur;
    r = blank_rsp();
    any = 1'b0;
    if (c.operation == stp_pkg::OP_TICK) begin
      for (int i = 0; i < Slots; i++) begin
        if (pool_state[i] != stp_pkg::ST_TICKING) continue;
        pool_left[i] = pool_left[i] - 32'd1;
        if (pool_left[i] != 0) continue;
        any = 1'b1;
        emit = events_open < Slots;
        if (emit) begin
          pool_pending[i]++;
          events_open++;
        end
        if (pool_mode[i] == stp_pkg::M_ONCE) pool_state[i] = stp_pkg::ST_DELETING;
        else if (pool_mode[i] == stp_pkg::M_NODEL) pool_state[i] = stp_pkg::ST_CREATED;
        else begin
          if (pool_overrun[i] != 16'hFFFF) pool_overrun[i]++;
          pool_left[i] = pool_interval[i];
        end
        if (emit) begin
          stp_pkg::rsp_t e;
          e = '0;
          e.status = stp_pkg::S_OK;
          e.result_id = id_of(i);
          e.expired = 1'b1;
          e.expired_tag = pool_tag[i];
          e.overrun_count = pool_overrun[i];
          expected_rsp.push_back(e);
        end
        if (pool_state[i] == stp_pkg::ST_DELETING && pool_pending[i] == 0) free_slot(i);
      end
      r.any_expired = any;
      expected_rsp.push_back(r);
      return;
    end
    if (c.operation == stp_pkg::OP_CREATE) begin
      if (c.interval == 0) r.status = stp_pkg::S_BAD_INTERVAL;
      else if (c.mode == stp_pkg::M_INVALID) r.status = stp_pkg::S_BAD_MODE;
      else if (free_count == 0) r.status = stp_pkg::S_FULL;
      else begin
        s = int'(free_slots[free_head]);
        free_head = free_head + 4'd1;
        free_count--;
        pool_mode[s] = c.mode;
        pool_overrun[s] = '0;
        pool_interval[s] = c.interval;
        pool_tag[s] = c.user_tag;
        pool_state[s] = stp_pkg::ST_CREATED;
        r.result_id = id_of(s);
      end
    end else if (c.operation == stp_pkg::OP_BAD) begin
      r.status = stp_pkg::S_ID_INVALID;
    end else begin
      s = int'(c.timer_id[3:0]);
      if (pool_gen[s] != c.timer_id[11:4]) r.status = stp_pkg::S_NOT_CREATED;
      else begin
        cur = pool_state[s];
        if (c.operation == stp_pkg::OP_DONE) begin
          if (pool_pending[s] == 0) r.status = stp_pkg::S_NOT_STARTED;
          else begin
            pool_pending[s]--;
            if (events_open > 0) events_open--;
            if (cur == stp_pkg::ST_DELETING && pool_pending[s] == 0) free_slot(s);
          end
        end else if (cur == stp_pkg::ST_UNUSED || cur == stp_pkg::ST_DELETING) begin
          r.status = stp_pkg::S_NOT_CREATED;
        end else if (c.operation == stp_pkg::OP_START) begin
          pool_overrun[s] = '0;
          pool_state[s] = stp_pkg::ST_TICKING;
          pool_left[s] = pool_interval[s];
        end else if (c.operation == stp_pkg::OP_STOP) begin
          if (cur == stp_pkg::ST_CREATED) r.status = stp_pkg::S_NOT_STARTED;
          else begin
            pool_state[s] = stp_pkg::ST_CREATED;
            pool_overrun[s] = '0;
          end
        end else if (c.operation == stp_pkg::OP_DELETE) begin
          pool_overrun[s] = '0;
          pool_state[s] = stp_pkg::ST_DELETING;
          if (pool_pending[s] == 0) free_slot(s);
        end else begin
          if (cur == stp_pkg::ST_CREATED) r.status = stp_pkg::S_NOT_STARTED;
          else r.remaining_ticks = pool_left[s];
        end
      end
    end
    expected_rsp.push_back(r);
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("mismatch at response %0d: %s expected %0h got %0h", rsps_seen, field, want, got);
  endtask

  task automatic add_word(logic [2:0] op, logic [11:0] id, logic [31:0] ivl,
                          logic [1:0] md, logic [31:0] tag, bit drain = 1'b0);
    pending_t p;
    p.word.operation = op;
    p.word.timer_id = id;
    p.word.interval = ivl;
    p.word.mode = md;
    p.word.user_tag = tag;
    p.drain = drain;
    word_queue.push_back(p);
  endtask

  // Random word, mostly aimed at live slots of low generation
  task automatic add_random_word(bit drain);
    logic [2:0] op;
    logic [11:0] id;
    logic [31:0] ivl;
    logic [1:0] md;
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) op = stp_pkg::OP_CREATE;
    else if (r < 40) op = stp_pkg::OP_START;
    else if (r < 46) op = stp_pkg::OP_STOP;
    else if (r < 53) op = stp_pkg::OP_DELETE;
    else if (r < 60) op = stp_pkg::OP_QUERY;
    else if (r < 82) op = stp_pkg::OP_TICK;
    else if (r < 98) op = stp_pkg::OP_DONE;
    else op = stp_pkg::OP_BAD;
    if ($urandom_range(0, 9) == 0) id = 12'($urandom);
    else id = {8'($urandom_range(0, 3)), 4'($urandom_range(0, Slots - 1))};
    r = $urandom_range(0, 19);
    if (r == 0) ivl = 32'd0;
    else if (r == 1) ivl = $urandom;
    else ivl = $urandom_range(1, 5);
    md = ($urandom_range(0, 14) == 0) ? stp_pkg::M_INVALID : 2'($urandom_range(0, 2));
    add_word(op, id, ivl, md, $urandom, drain);
  endtask

  // Accept words into the model and check response words
  always @(posedge clk) begin
    took = cmd.valid && cmd.ready && !rst;
    if (took) begin
      pool_apply(cmd.data);
      words_in++;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      stp_pkg::rsp_t w;
      stp_pkg::rsp_t g;
      g = rsp.data;
      if (expected_rsp.size() == 0) begin
        report("extra response word, status", 32'd0, 32'(g.status));
      end else begin
        w = expected_rsp.pop_front();
        if (g.status !== w.status) report("status", 32'(w.status), 32'(g.status));
        if (g.result_id !== w.result_id)
          report("result_id", 32'(w.result_id), 32'(g.result_id));
        if (g.remaining_ticks !== w.remaining_ticks)
          report("remaining_ticks", w.remaining_ticks, g.remaining_ticks);
        if (g.expired !== w.expired) report("expired", 32'(w.expired), 32'(g.expired));
        if (g.expired_tag !== w.expired_tag)
          report("expired_tag", w.expired_tag, g.expired_tag);
        if (g.overrun_count !== w.overrun_count)
          report("overrun_count", 32'(w.overrun_count), 32'(g.overrun_count));
        if (g.any_expired !== w.any_expired)
          report("any_expired", 32'(w.any_expired), 32'(g.any_expired));
        if (g.last !== w.last) report("last", 32'(w.last), 32'(g.last));
        if (w.expired) expiries_seen++;
      end
      rsps_seen++;
    end
  end

  // Feed command words, with gaps and drain points
  always @(negedge clk) begin
    logic v;
    pending_t p;
    v = cmd.valid;
    if (rst) begin
      v = 1'b0;
    end else begin
      if (v && took) v = 1'b0;
      if (!v) begin
        if (send_gap > 0) send_gap--;
        else if (word_queue.size() > 0 &&
                 !(word_queue[0].drain && expected_rsp.size() > 0)) begin
          p = word_queue.pop_front();
          cmd.data <= p.word;
          v = 1'b1;
          send_gap = pick_gap();
        end
      end
    end
    cmd.valid <= v;
    took = 1'b0;
  end

  // Drive response ready: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (!long_hold_done && words_in >= 40) begin
      long_hold_done = 1'b1;
      stall_left = 400;
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses pending", cycles, expected_rsp.size());
      $display("FAIL software_timer_pool");
      $finish;
    end
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.data = '0;
    rsp.ready = 1'b0;
    pool_clear();

    // Directed: bad creates, each mode, expiry kinds, stale ids, odd opcode
    add_word(stp_pkg::OP_CREATE, 12'd0, 32'd0, stp_pkg::M_ONCE, 32'h0);
    add_word(stp_pkg::OP_CREATE, 12'd0, 32'd1, stp_pkg::M_INVALID, 32'h0);
    add_word(stp_pkg::OP_CREATE, 12'd0, 32'd1, stp_pkg::M_ONCE, 32'hFFFF_FFFF);
    add_word(stp_pkg::OP_CREATE, 12'd0, 32'd2, stp_pkg::M_PERIODIC, 32'h5555_AAAA);
    add_word(stp_pkg::OP_CREATE, 12'd0, 32'd1, stp_pkg::M_NODEL, 32'hAAAA_5555);
    add_word(stp_pkg::OP_QUERY, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_STOP, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_START, 12'd0, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_START, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_START, 12'd2, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_QUERY, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_TICK, 12'd0, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_TICK, 12'd0, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_DONE, 12'd3, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_DONE, 12'd0, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_DONE, 12'd0, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_START, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_DELETE, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_DONE, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_DONE, 12'd1, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_BAD, 12'hFFF, 32'hFFFF_FFFF, stp_pkg::M_INVALID, 32'hFFFF_FFFF);
    add_word(stp_pkg::OP_QUERY, 12'hFFF, 32'd0, stp_pkg::M_ONCE, 32'd0);
    add_word(stp_pkg::OP_CREATE, 12'hFFF, 32'hFFFF_FFFF, stp_pkg::M_PERIODIC, 32'h1234_5678);
    add_word(stp_pkg::OP_START, 12'h013, 32'd0, stp_pkg::M_ONCE, 32'd0, 1'b1);
    add_word(stp_pkg::OP_QUERY, 12'h013, 32'd0, stp_pkg::M_ONCE, 32'd0);

    // Random part, with a drain pause partway through
    for (int i = 0; i < 95; i++) add_random_word(i == 50);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (word_queue.size() == 0 && !cmd.valid && expected_rsp.size() == 0);
    repeat (200) @(posedge clk);

    $display("covered %0d command words, %0d response words, %0d expiry events",
             words_in, rsps_seen, expiries_seen);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("PASS software_timer_pool");
    end else begin
      $display("%0d mismatches, %0d responses missing", errors, expected_rsp.size());
      $display("FAIL software_timer_pool");
    end
    $finish;
  end
endmodule
